// ===== hdl/jpp_pkg.sv =====
// ---------------------------------------------------------------------------
// JSON pretty printer package
// Shared constants, character codes, sequencer states and plan types.
// ---------------------------------------------------------------------------
`default_nettype none

package jpp_pkg;

  // Nesting bound and derived widths
  localparam int MaxDepth = 16;
  localparam int LvlW     = $clog2(MaxDepth + 1) + 1;
  localparam int CntW     = $clog2(2 * MaxDepth + 1);

  typedef logic signed [LvlW-1:0] level_t;
  typedef logic [CntW-1:0]        ind_cnt_t;

  localparam level_t LvlMax = LvlW'(MaxDepth);
  localparam level_t LvlMin = -LvlMax;

  // Character codes
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;

  // Emission sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HEAD = 5'b00010,
    S_NL   = 5'b00100,
    S_IND  = 5'b01000,
    S_TAIL = 5'b10000
  } seq_state_e;

  // Emission plan for one input byte
  typedef struct packed {
    logic       drop;
    logic       has_head;
    logic [7:0] head_byte;
    logic       has_nl;
    ind_cnt_t   ind_cnt;
    logic       has_tail;
    logic [7:0] tail_byte;
    logic       sat;
  } plan_t;

  // Context kept between bytes
  typedef struct packed {
    logic       string_open;
    logic [7:0] prior_byte;
    level_t     nest_level;
  } ctx_t;

endpackage

`default_nettype wire

// ===== hdl/jpp_if.sv =====
// ---------------------------------------------------------------------------
// JSON pretty printer channels
// Valid/ready channels for raw input bytes and formatted output bytes.
// ---------------------------------------------------------------------------
`default_nettype none

interface jpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       doc_start;

  modport source (output valid, output in_byte, output doc_start, input ready);
  modport sink   (input valid, input in_byte, input doc_start, output ready);
endinterface

interface jpp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       depth_saturated;

  modport source (output valid, output out_byte, output run_last,
                  output depth_saturated, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input depth_saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/jpp_decode.sv =====
// ---------------------------------------------------------------------------
// JSON pretty printer byte decoder
// Classifies one input byte, updates the context and builds its emission plan.
// ---------------------------------------------------------------------------
`default_nettype none

module jpp_decode import jpp_pkg::*; (
  input  logic [7:0] in_byte_i,
  input  logic       doc_start_i,
  input  ctx_t       ctx_i,
  output ctx_t       ctx_o,
  output plan_t      plan_o
);

  ctx_t   cur;
  level_t lvl_n;
  logic   sat;

  // Indentation for the updated level: two spaces per positive level
  function automatic ind_cnt_t indent_of(level_t lvl);
    ind_cnt_t cnt;
    cnt = '0;
    if (lvl > 0) begin
      cnt = CntW'(lvl[LvlW-2:0]) << 1;
    end
    return cnt;
  endfunction

  always_comb begin
    cur = doc_start_i ? '0 : ctx_i;

    lvl_n = cur.nest_level;
    sat   = 1'b0;

    plan_o           = '0;
    plan_o.head_byte = in_byte_i;
    plan_o.tail_byte = in_byte_i;

    ctx_o            = cur;
    ctx_o.prior_byte = in_byte_i;

    if (cur.string_open) begin
      // Pass string bytes; an unescaped quote closes the string
      plan_o.has_head = 1'b1;
      if (in_byte_i == ChQuote && cur.prior_byte != ChBslash) begin
        ctx_o.string_open = 1'b0;
      end
    end else begin
      unique case (in_byte_i) inside
        ChQuote: begin
          plan_o.has_head   = 1'b1;
          ctx_o.string_open = 1'b1;
        end
        ChLBrace, ChLBrack: begin
          if (cur.nest_level >= LvlMax) begin
            sat = 1'b1;
          end else begin
            lvl_n = cur.nest_level + level_t'(1);
          end
          plan_o.has_head = 1'b1;
          plan_o.has_nl   = 1'b1;
          plan_o.ind_cnt  = indent_of(lvl_n);
        end
        ChRBrace, ChRBrack: begin
          if (cur.nest_level <= LvlMin) begin
            sat = 1'b1;
          end else begin
            lvl_n = cur.nest_level - level_t'(1);
          end
          plan_o.has_nl   = 1'b1;
          plan_o.ind_cnt  = indent_of(lvl_n);
          plan_o.has_tail = 1'b1;
        end
        ChComma: begin
          plan_o.has_head = 1'b1;
          plan_o.has_nl   = 1'b1;
          plan_o.ind_cnt  = indent_of(cur.nest_level);
        end
        ChColon: begin
          plan_o.has_head  = 1'b1;
          plan_o.has_tail  = 1'b1;
          plan_o.tail_byte = ChSpace;
        end
        ChSpace, ChTab, ChNl, ChCr: begin
          plan_o.drop = 1'b1;
        end
        default: begin
          plan_o.has_head = 1'b1;
        end
      endcase
    end

    plan_o.sat       = sat;
    ctx_o.nest_level = lvl_n;
  end

endmodule

`default_nettype wire

// ===== hdl/jpp_seq.sv =====
// ---------------------------------------------------------------------------
// JSON pretty printer emission sequencer
// Steps through head, newline, indentation and tail bytes of one plan,
// reusing one down counter for the indentation run, into an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module jpp_seq import jpp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  plan_t     plan_i,
  output logic      busy_o,
  jpp_out_if.source out_o
);

  seq_state_e state_q, state_d;
  logic [7:0] head_q, head_d;
  logic [7:0] tail_q, tail_d;
  logic       has_nl_q, has_nl_d;
  logic       has_tail_q, has_tail_d;
  logic       sat_q, sat_d;
  ind_cnt_t   cnt_q, cnt_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_sat_q, out_sat_d;

  logic       load;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_last;
  seq_state_e after_ind;

  assign load      = !out_valid_q || out_o.ready;
  assign after_ind = has_tail_q ? S_TAIL : S_IDLE;

  // Sequence the bytes of the current plan
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    has_nl_d   = has_nl_q;
    has_tail_d = has_tail_q;
    sat_d      = sat_q;
    cnt_d      = cnt_q;
    emit       = 1'b0;
    emit_byte  = head_q;
    emit_last  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          head_d     = plan_i.head_byte;
          tail_d     = plan_i.tail_byte;
          has_nl_d   = plan_i.has_nl;
          has_tail_d = plan_i.has_tail;
          sat_d      = plan_i.sat;
          cnt_d      = plan_i.ind_cnt;
          if (plan_i.drop) begin
            state_d = S_IDLE;
          end else if (plan_i.has_head) begin
            state_d = S_HEAD;
          end else if (plan_i.has_nl) begin
            state_d = S_NL;
          end else begin
            state_d = S_TAIL;
          end
        end
      end
      S_HEAD: begin
        if (load) begin
          emit      = 1'b1;
          emit_byte = head_q;
          emit_last = !has_nl_q && !has_tail_q;
          state_d   = has_nl_q ? S_NL : after_ind;
        end
      end
      S_NL: begin
        if (load) begin
          emit      = 1'b1;
          emit_byte = ChNl;
          emit_last = (cnt_q == '0) && !has_tail_q;
          state_d   = (cnt_q != '0) ? S_IND : after_ind;
        end
      end
      S_IND: begin
        if (load) begin
          emit      = 1'b1;
          emit_byte = ChSpace;
          emit_last = (cnt_q == CntW'(1)) && !has_tail_q;
          cnt_d     = cnt_q - CntW'(1);
          state_d   = (cnt_q != CntW'(1)) ? S_IND : after_ind;
        end
      end
      S_TAIL: begin
        if (load) begin
          emit      = 1'b1;
          emit_byte = tail_q;
          emit_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Load or drain the output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_sat_d   = out_sat_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      out_last_d  = emit_last;
      out_sat_d   = sat_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q     <= head_d;
    tail_q     <= tail_d;
    has_nl_q   <= has_nl_d;
    has_tail_q <= has_tail_d;
    sat_q      <= sat_d;
    cnt_q      <= cnt_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_sat_q  <= out_sat_d;
  end

  assign busy_o                = (state_q != S_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.out_byte        = out_byte_q;
  assign out_o.run_last        = out_last_q;
  assign out_o.depth_saturated = out_sat_q;

endmodule

`default_nettype wire

// ===== hdl/json_pretty_printer_unit.sv =====
// ---------------------------------------------------------------------------
// JSON pretty printer unit
// Re-indents a JSON byte stream: one raw byte in, zero or more bytes out.
// ---------------------------------------------------------------------------
// A raw byte is taken when the unit is idle and produces its formatted bytes
// one per cycle through an output register while the output is ready, from
// zero up to 2 + 2*MaxDepth bytes; a dropped whitespace byte produces none.
// No new byte is taken until the sequencer has put the last of them in that
// register. Backpressure on the output stalls the sequencer, whose single
// down counter walks the indentation run. The last byte of each run carries
// run_last; depth_saturated marks every byte of a structure byte whose level
// change was held at the nesting bound. Raising doc_start with a byte clears
// the string flag, previous byte and nesting level first.
// ---------------------------------------------------------------------------
`default_nettype none

module json_pretty_printer_unit import jpp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  jpp_in_if.sink    in_i,
  jpp_out_if.source out_o
);

  ctx_t  ctx_q, ctx_d;
  plan_t plan;
  logic  busy;
  logic  accept;

  assign in_i.ready = !busy;
  assign accept     = in_i.valid && in_i.ready;

  // Classify the request byte against the held context
  jpp_decode u_decode (
    .in_byte_i   (in_i.in_byte),
    .doc_start_i (in_i.doc_start),
    .ctx_i       (ctx_q),
    .ctx_o       (ctx_d),
    .plan_o      (plan)
  );

  // Emit the formatted bytes
  jpp_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .plan_i  (plan),
    .busy_o  (busy),
    .out_o   (out_o)
  );

  // Advance the context on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= '0;
    end else if (accept) begin
      ctx_q <= ctx_d;
    end
  end

endmodule

`default_nettype wire
